/* design/btk_pkg.sv */
`timescale 1ns / 1ps
// Package for the bounded top-k sorted list: word structs, cell control struct,
// register indexes and fixed field widths. No dependencies.
package btk_pkg;

  localparam int KEY_W     = 32;
  localparam int IN_TAG_W  = 16;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd1;

  typedef struct packed {
    logic [KEY_W-1:0]    item_key;
    logic [IN_TAG_W-1:0] item_tag;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  entry_count;
    logic                evicted_valid;
    logic [KEY_W-1:0]    evicted_key;
    logic [IN_TAG_W-1:0] evicted_tag;
    logic                head_valid;
    logic [KEY_W-1:0]    head_key;
    logic [IN_TAG_W-1:0] head_tag;
  } out_word_t;

  // broadcast to every cell for one insert
  typedef struct packed {
    logic             load;
    logic             keep_small;
    logic             evict;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

/* design/btk_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted list: holds a key and tag, compares against the new key,
// and takes its next entry from itself, a neighbor or the new word. Uses btk_pkg.
module btk_cell #(
  parameter int TAG_BITS = 16
) (
  input  logic                     clk_i,
  input  btk_pkg::cell_ctrl_t      ctrl_i,
  input  logic [TAG_BITS-1:0]      new_tag_i,
  input  logic                     slot_valid_i,
  input  logic                     run_in_i,
  input  logic                     run_far_i,
  input  logic [btk_pkg::KEY_W-1:0] left_key_i,
  input  logic [TAG_BITS-1:0]      left_tag_i,
  input  logic [btk_pkg::KEY_W-1:0] right_key_i,
  input  logic [TAG_BITS-1:0]      right_tag_i,
  output logic                     run_out_o,
  output logic [btk_pkg::KEY_W-1:0] key_o,
  output logic [TAG_BITS-1:0]      tag_o,
  output logic [btk_pkg::KEY_W-1:0] key_nxt_o,
  output logic [TAG_BITS-1:0]      tag_nxt_o
);
  import btk_pkg::*;

  logic [KEY_W-1:0]    key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic                ahead;

  assign ahead     = slot_valid_i && (ctrl_i.keep_small ? (key_q > ctrl_i.key)
                                                        : (key_q < ctrl_i.key));
  assign run_out_o = run_in_i && ahead;

  always_comb begin
    if (ctrl_i.evict) begin
      if (run_far_i) begin
        key_d = right_key_i;
        tag_d = right_tag_i;
      end else if (run_out_o) begin
        key_d = ctrl_i.key;
        tag_d = new_tag_i;
      end else begin
        key_d = key_q;
        tag_d = tag_q;
      end
    end else begin
      if (run_out_o) begin
        key_d = key_q;
        tag_d = tag_q;
      end else if (run_in_i) begin
        key_d = ctrl_i.key;
        tag_d = new_tag_i;
      end else begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      key_q <= key_d;
      tag_q <= tag_d;
    end
  end

  assign key_o     = key_q;
  assign tag_o     = tag_q;
  assign key_nxt_o = key_d;
  assign tag_nxt_o = tag_d;

endmodule

/* design/bounded_top_k_sorted_list.sv */
`timescale 1ns / 1ps
// Top level of the bounded top-k sorted list: config registers, a chain of
// btk_cell slots, count tracking and the output word register. Uses btk_pkg.
//
//  channel | signals                           | word
//  in      | in_valid_i  in_stall_o  in_word_i   | btk_pkg::in_word_t
//  out     | out_valid_o out_stall_i out_word_o  | btk_pkg::out_word_t
//  cfg     | cfg_we_i    cfg_idx_i   cfg_data_i  | keep_mode, capacity
//
// One word per cycle while the output is not stalled: all cells compare and shift
// in the cycle a word is taken; the output word register captures the result.
// The insert position travels cell to cell as a one-bit run chain.
// Reset empties the list and sets keep_mode 0, capacity 16; slot contents are
// undefined until written. A stalled output word stalls the input.
module bounded_top_k_sorted_list #(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  btk_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output btk_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [btk_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [btk_pkg::CFG_W-1:0]     cfg_data_i
);
  import btk_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  logic             mode_q;
  logic [CFG_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  out_word_t        out_q;

  logic             accept;
  logic [CMP_W-1:0] cap_ext, cap_eff, n_plus;
  logic             evict;
  cell_ctrl_t       ctrl;
  logic [TAG_BITS-1:0] new_tag;

  logic                run [DEPTH+2];
  logic [KEY_W-1:0]    key_cur [DEPTH];
  logic [TAG_BITS-1:0] tag_cur [DEPTH];
  logic [KEY_W-1:0]    key_nxt [DEPTH];
  logic [TAG_BITS-1:0] tag_nxt [DEPTH];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign cap_ext = CMP_W'(cap_q);
  assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign n_plus  = CMP_W'(count_q) + CMP_W'(1);
  assign evict   = n_plus > cap_eff;
  assign count_d = evict ? count_q : count_q + CNT_W'(1);

  assign new_tag         = TAG_BITS'(in_word_i.item_tag);
  assign ctrl.load       = accept;
  assign ctrl.keep_small = mode_q;
  assign ctrl.evict      = evict;
  assign ctrl.key        = in_word_i.item_key;

  assign run[0]       = 1'b1;
  assign run[DEPTH+1] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0]    lk, rk;
    logic [TAG_BITS-1:0] lt, rt;
    if (i == 0) begin : g_first
      assign lk = '0;
      assign lt = '0;
    end else begin : g_mid
      assign lk = key_cur[i-1];
      assign lt = tag_cur[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = '0;
      assign rt = '0;
    end else begin : g_body
      assign rk = key_cur[i+1];
      assign rt = tag_cur[i+1];
    end
    btk_cell #(.TAG_BITS(TAG_BITS)) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_tag_i    (new_tag),
      .slot_valid_i (CMP_W'(i) < CMP_W'(count_q)),
      .run_in_i     (run[i]),
      .run_far_i    (run[i+2]),
      .left_key_i   (lk),
      .left_tag_i   (lt),
      .right_key_i  (rk),
      .right_tag_i  (rt),
      .run_out_o    (run[i+1]),
      .key_o        (key_cur[i]),
      .tag_o        (tag_cur[i]),
      .key_nxt_o    (key_nxt[i]),
      .tag_nxt_o    (tag_nxt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      cap_q       <= CFG_W'(16);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEEP_MODE: mode_q <= cfg_data_i[0];
          REG_CAPACITY:  cap_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.entry_count   <= COUNT_W'(count_d);
      out_q.evicted_valid <= evict;
      out_q.evicted_key   <= !evict ? '0 : (run[1] ? key_cur[0] : in_word_i.item_key);
      out_q.evicted_tag   <= !evict ? '0 : IN_TAG_W'(run[1] ? tag_cur[0] : new_tag);
      out_q.head_valid    <= count_d != '0;
      out_q.head_key      <= (count_d != '0) ? key_nxt[0] : '0;
      out_q.head_tag      <= (count_d != '0) ? IN_TAG_W'(tag_nxt[0]) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(count_q) <= CMP_W'(DEPTH))
    else $error("held count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !evict |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("count did not grow on insert without eviction");

  a_evict_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && evict |=> count_q == $past(count_q))
    else $error("count changed on evicting insert");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.head_valid |->
      out_word_o.head_key == '0 && out_word_o.head_tag == '0 &&
      out_word_o.entry_count == '0)
    else $error("empty list reports a head");

endmodule

/* tb/tb_bounded_top_k_sorted_list.sv */
`timescale 1ns / 1ps
// Testbench for bounded_top_k_sorted_list: directed and random inserts checked
// word by word against an in-bench model of the sorted list. Uses btk_pkg.
module tb_bounded_top_k_sorted_list;
  import btk_pkg::*;

  localparam int DEPTH = 16;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_word_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_KEEP_MODE;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // model of the list
  logic [KEY_W-1:0]    list_key [0:DEPTH];
  logic [IN_TAG_W-1:0] list_tag [0:DEPTH];
  int                  held = 0;
  logic                keep_small = 1'b0;
  int                  cap_reg = 16;

  out_word_t pending_results[$];
  int        error_count = 0;
  bit        idle_on = 1'b1;

  bounded_top_k_sorted_list #(.DEPTH(DEPTH), .TAG_BITS(16)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 31);
  end

  function automatic out_word_t rank_insert(logic [KEY_W-1:0] key, logic [IN_TAG_W-1:0] tag);
    out_word_t           res;
    int                  lim;
    int                  n;
    int                  pos;
    logic                gone;
    logic [KEY_W-1:0]    gone_key;
    logic [IN_TAG_W-1:0] gone_tag;
    lim = (cap_reg > DEPTH) ? DEPTH : cap_reg;
    n = held;
    pos = 0;
    while (pos < n && (keep_small ? (list_key[pos] > key) : (list_key[pos] < key))) pos++;
    for (int i = n; i > pos; i--) begin
      list_key[i] = list_key[i-1];
      list_tag[i] = list_tag[i-1];
    end
    list_key[pos] = key;
    list_tag[pos] = tag;
    n++;
    gone = 1'b0;
    gone_key = '0;
    gone_tag = '0;
    if (n > lim) begin
      gone = 1'b1;
      gone_key = list_key[0];
      gone_tag = list_tag[0];
      for (int i = 0; i + 1 < n; i++) begin
        list_key[i] = list_key[i+1];
        list_tag[i] = list_tag[i+1];
      end
      n--;
    end
    held = n;
    res.entry_count   = n[COUNT_W-1:0];
    res.evicted_valid = gone;
    res.evicted_key   = gone_key;
    res.evicted_tag   = gone_tag;
    res.head_valid    = (n > 0);
    res.head_key      = (n > 0) ? list_key[0] : '0;
    res.head_tag      = (n > 0) ? list_tag[0] : '0;
    return res;
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // outputs are stable from negedge to the next posedge, so the handshake is
  // judged here
  always @(negedge clk_i) begin : result_check
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output word %0h", out_word_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("entry_count", KEY_W'(want.entry_count),
                    KEY_W'(out_word_o.entry_count));
        check_field("evicted_valid", KEY_W'(want.evicted_valid),
                    KEY_W'(out_word_o.evicted_valid));
        check_field("evicted_key", want.evicted_key, out_word_o.evicted_key);
        check_field("evicted_tag", KEY_W'(want.evicted_tag),
                    KEY_W'(out_word_o.evicted_tag));
        check_field("head_valid", KEY_W'(want.head_valid),
                    KEY_W'(out_word_o.head_valid));
        check_field("head_key", want.head_key, out_word_o.head_key);
        check_field("head_tag", KEY_W'(want.head_tag), KEY_W'(out_word_o.head_tag));
      end
    end
  end

  task automatic send_item(logic [KEY_W-1:0] key, logic [IN_TAG_W-1:0] tag);
    bit taken;
    if (idle_on) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{item_key: key, item_tag: tag};
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.push_back(rank_insert(key, tag));
  endtask

  task automatic settle_list();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    settle_list();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEEP_MODE) keep_small = data[0];
    else cap_reg = int'(data);
  endtask

  task automatic test_key_extremes();
    send_item(32'h0000_0000, 16'hFFFF);
    send_item(32'hFFFF_FFFF, 16'h0000);
    send_item(32'h0000_0000, 16'h0001);  // equal to head: becomes new head
    send_item(32'h0000_0005, 16'h0002);
    send_item(32'h8000_0000, 16'h8000);
  endtask

  task automatic test_capacity_edges();
    write_reg(REG_CAPACITY, 5'd0);
    send_item(32'h0000_0010, 16'h1234);
    send_item(32'hFFFF_FFFF, 16'hABCD);
    write_reg(REG_CAPACITY, 5'd31);      // above depth
    send_item(32'h0000_0007, 16'h0007);
    send_item(32'h0000_0003, 16'h0003);
    write_reg(REG_CAPACITY, 5'd2);       // below count: one dropped per insert
    send_item(32'h0000_0001, 16'h0011);
    send_item(32'h0000_0009, 16'h0012);
    send_item(32'h0000_0009, 16'h0013);
    send_item(32'h0000_0002, 16'h0014);
  endtask

  task automatic test_mode_switch();
    write_reg(REG_KEEP_MODE, 5'b10101);  // upper bits ignored
    write_reg(REG_CAPACITY, 5'd16);
    send_item(32'h0000_0008, 16'h0021);
    send_item(32'h0000_0009, 16'h0022);
    send_item(32'h0000_0009, 16'h0023);
    send_item(32'h0000_0001, 16'h0024);
    write_reg(REG_CAPACITY, 5'd1);
    send_item(32'hFFFF_FFFF, 16'h0025);
    send_item(32'h0000_0000, 16'h0026);
    write_reg(REG_KEEP_MODE, 5'b01110);
    send_item(32'h0000_0004, 16'h0027);
  endtask

  task automatic test_random_stream();
    logic [KEY_W-1:0] key;
    int               sel;
    for (int phase = 0; phase < 10; phase++) begin
      write_reg(REG_KEEP_MODE, CFG_W'($urandom_range(31)));
      case (phase)
        0: write_reg(REG_CAPACITY, 5'd16);
        1: write_reg(REG_CAPACITY, 5'd0);
        2: write_reg(REG_CAPACITY, 5'd31);
        3: write_reg(REG_CAPACITY, 5'd1);
        default: write_reg(REG_CAPACITY, CFG_W'($urandom_range(31)));
      endcase
      idle_on = (phase != 5);
      for (int k = 0; k < 100; k++) begin
        sel = $urandom_range(9);
        if (sel < 5) key = $urandom_range(20);
        else if (sel < 8) key = $urandom;
        else if (sel == 8) key = 32'h0000_0000;
        else key = 32'hFFFF_FFFF;
        send_item(key, IN_TAG_W'($urandom));
      end
      idle_on = 1'b1;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_key_extremes();
    test_capacity_edges();
    test_mode_switch();
    test_random_stream();
    settle_list();
    repeat (5) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected words never arrived", pending_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* bounded_top_k_sorted_list.f */
design/btk_pkg.sv
design/btk_cell.sv
design/bounded_top_k_sorted_list.sv
tb/tb_bounded_top_k_sorted_list.sv
